@@ hw/rtl/center_crop_area_downscale_assert.svh @@
// Assertion macros shared by the center crop area downscaler RTL.
// Needs no other file; the including module supplies clock and reset names.
`ifndef CENTER_CROP_AREA_DOWNSCALE_ASSERT_SVH
`define CENTER_CROP_AREA_DOWNSCALE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ccad_pkg.sv @@
// Shared constants, types and command structs of the center crop area downscaler.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ccad_pkg;

    localparam int OUT_SIDE        = 96;
    localparam int MAX_SOURCE_SIDE = 2048;
    localparam int CH_W            = 8;
    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 1;

    localparam int SIDE_W  = $clog2(MAX_SOURCE_SIDE + 1);
    localparam int POS_W   = $clog2(MAX_SOURCE_SIDE);
    localparam int GRID_W  = $clog2(OUT_SIDE);
    localparam int QUO_W   = $clog2(MAX_SOURCE_SIDE / OUT_SIDE + 1);
    localparam int REM_W   = $clog2(OUT_SIDE);
    localparam int BLK_MAX = MAX_SOURCE_SIDE / OUT_SIDE + 1;
    localparam int BLK_W   = $clog2(BLK_MAX + 1);
    localparam int CNT_W   = $clog2(BLK_MAX * BLK_MAX + 1);
    localparam int SUM_W   = $clog2(BLK_MAX * BLK_MAX * ((1 << CH_W) - 1) + 1);
    localparam int DIV_W   = CNT_W + CH_W;
    localparam int BIT_W   = $clog2(CH_W);

    localparam int RCP_SH  = SIDE_W + REM_W;
    localparam int RCP     = (1 << RCP_SH) / OUT_SIDE;
    localparam int RCP_W   = $clog2(RCP + 1);
    localparam int PROD_W  = SIDE_W + RCP_W;

    localparam int IN_DATA_W    = 3 * CH_W;
    localparam int OUT_FIELDS_W = 3 * CH_W + 2 * GRID_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    typedef logic [2:0][SUM_W-1:0] t_sum_rgb;
    typedef logic [2:0][CH_W-1:0]  t_pix_rgb;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_GEOM,
        ST_INIT,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             geom;
        logic             init;
        logic             step;
        logic             mul;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
    } t_dp_status;

endpackage

@@ hw/rtl/ccad_ctrl.sv @@
// Controller state machine of the center crop area downscaler.
// Depends on ccad_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "center_crop_area_downscale_assert.svh"

module ccad_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  ccad_pkg::t_dp_status i_status,
    output ccad_pkg::t_dp_cmd    o_cmd
);
    import ccad_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [BIT_W-1:0] r_bit;
    logic [BIT_W-1:0] n_bit;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_GEOM;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            ST_GEOM: begin
                o_cmd.geom = 1'b1;
                n_state    = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_IDLE: begin
                o_s_tready = !i_cfg_we;
                if (i_s_tvalid && !i_cfg_we) begin
                    o_cmd.step = 1'b1;
                    if (i_status.emit) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_bit     = BIT_W'(CH_W - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_bit  = r_bit;
                if (r_bit == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_GEOM;
            end
        endcase
        if (i_cfg_we) begin
            n_state = ST_GEOM;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `CCAD_ASSERT_NEXT(a_emit_starts_div, i_clk, i_rst_n, o_cmd.step && i_status.emit, r_state == ST_MUL, "Block-completing transfer did not start the divide.")
    `CCAD_ASSERT_NOW(a_load_into_free, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_m_tready, "Output register overwritten before transfer.")
    `CCAD_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == ST_DIV && r_bit == '0 && !i_cfg_we, r_state == ST_FIN, "Divide did not end after the last quotient bit.")

endmodule

@@ hw/rtl/ccad_dpath.sv @@
// Datapath of the center crop area downscaler: geometry, raster position,
// per-column sum memory and shift-subtract divider. Depends on ccad_pkg.
`timescale 1ns / 1ps

module ccad_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ccad_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ccad_pkg::CFG_W-1:0]           i_cfg_data,
    input  ccad_pkg::t_dp_cmd                    i_cmd,
    output ccad_pkg::t_dp_status                 o_status,
    input  logic [ccad_pkg::IN_DATA_W-1:0]       i_pixel,
    output logic [ccad_pkg::OUT_DATA_W-1:0]      o_tdata,
    output logic                                 o_tlast
);
    import ccad_pkg::*;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v < CFG_W'(OUT_SIDE)) begin
            res = SIDE_W'(OUT_SIDE);
        end else if (v > CFG_W'(MAX_SOURCE_SIDE)) begin
            res = SIDE_W'(MAX_SOURCE_SIDE);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

    logic [SIDE_W-1:0] r_width;
    logic [SIDE_W-1:0] r_height;
    logic [SIDE_W-1:0] r_crop;
    logic [SIDE_W-1:0] r_x_lo;
    logic [SIDE_W-1:0] r_y_lo;
    logic [SIDE_W-1:0] r_x_hi;
    logic [SIDE_W-1:0] r_y_hi;
    logic [QUO_W-1:0]  r_q0;
    logic [QUO_W-1:0]  r_q;
    logic [REM_W-1:0]  r_r;

    logic [POS_W-1:0]  r_src_col,   n_src_col;
    logic [POS_W-1:0]  r_src_row,   n_src_row;
    logic [GRID_W-1:0] r_grid_col,  n_grid_col;
    logic [GRID_W-1:0] r_grid_row,  n_grid_row;
    logic [SIDE_W-1:0] r_col_start, n_col_start;
    logic [SIDE_W-1:0] r_col_end,   n_col_end;
    logic [SIDE_W-1:0] r_row_start, n_row_start;
    logic [SIDE_W-1:0] r_row_end,   n_row_end;
    logic [REM_W-1:0]  r_col_rem,   n_col_rem;
    logic [REM_W-1:0]  r_row_rem,   n_row_rem;

    t_sum_rgb          r_mem [OUT_SIDE];
    logic [OUT_SIDE-1:0] r_valid;
    t_sum_rgb          r_rd;

    logic [BLK_W-1:0]  r_bw;
    logic [BLK_W-1:0]  r_bh;
    logic [CNT_W-1:0]  r_cnt;
    t_sum_rgb          r_drem;
    t_pix_rgb          r_quo;
    logic [GRID_W-1:0] r_tag_col;
    logic [GRID_W-1:0] r_tag_row;
    logic              r_tag_last;
    t_pix_rgb          r_out_quo;
    logic [GRID_W-1:0] r_out_col;
    logic [GRID_W-1:0] r_out_row;
    logic              r_out_last;

    logic [SIDE_W-1:0] crop_w;
    logic [PROD_W-1:0] prod;
    logic [SIDE_W-1:0] r0;
    logic              fix;
    logic [QUO_W-1:0]  q_fix;
    logic [REM_W-1:0]  r_fix;

    logic [SIDE_W-1:0] x_ext, y_ext, x_nxt, y_nxt;
    logic              in_crop, col_hit, row_hit, emit, last_col, last_row;
    logic [REM_W:0]    col_acc, row_acc;
    logic              col_carry, row_carry;
    logic [REM_W-1:0]  col_rem_nxt, row_rem_nxt;
    logic [SIDE_W-1:0] col_end_nxt, row_end_nxt;

    t_sum_rgb          sum_new;
    logic              mem_we;
    t_sum_rgb          mem_wdata;

    logic [DIV_W-1:0]  trial;
    t_sum_rgb          drem_nxt;
    logic [2:0]        qbit;

    // Configuration registers; the controller restarts the frame after a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(OUT_SIDE);
            r_height <= SIDE_W'(OUT_SIDE);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= clamp_side(i_cfg_data);
                CFG_HEIGHT: r_height <= clamp_side(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Crop geometry; the block side (crop side over the output side) is taken by a reciprocal multiply.
    assign crop_w = (r_width < r_height) ? r_width : r_height;
    assign prod   = PROD_W'(crop_w) * PROD_W'(RCP);
    assign r0     = r_crop - SIDE_W'(r_q0) * SIDE_W'(OUT_SIDE);
    assign fix    = r0 >= SIDE_W'(OUT_SIDE);
    assign q_fix  = r_q0 + QUO_W'(fix);
    assign r_fix  = REM_W'(fix ? r0 - SIDE_W'(OUT_SIDE) : r0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.geom) begin
            r_crop <= crop_w;
            r_x_lo <= (r_width - crop_w) >> 1;
            r_y_lo <= (r_height - crop_w) >> 1;
            r_q0   <= QUO_W'(prod >> RCP_SH);
        end
        if (i_cmd.init) begin
            r_q    <= q_fix;
            r_r    <= r_fix;
            r_x_hi <= r_x_lo + r_crop;
            r_y_hi <= r_y_lo + r_crop;
        end
    end

    assign x_ext    = SIDE_W'(r_src_col);
    assign y_ext    = SIDE_W'(r_src_row);
    assign x_nxt    = x_ext + 1'b1;
    assign y_nxt    = y_ext + 1'b1;
    assign in_crop  = (x_ext >= r_x_lo) && (x_ext < r_x_hi)
                   && (y_ext >= r_y_lo) && (y_ext < r_y_hi);
    assign col_hit  = x_nxt == r_col_end;
    assign row_hit  = y_nxt == r_row_end;
    assign emit     = in_crop && col_hit && row_hit;
    assign last_col = r_grid_col == GRID_W'(OUT_SIDE - 1);
    assign last_row = r_grid_row == GRID_W'(OUT_SIDE - 1);

    assign o_status.emit = emit;

    // Block edges advance by the whole quotient plus a carry from the remainder.
    assign col_acc     = {1'b0, r_col_rem} + {1'b0, r_r};
    assign col_carry   = col_acc >= (REM_W + 1)'(OUT_SIDE);
    assign col_rem_nxt = REM_W'(col_carry ? col_acc - (REM_W + 1)'(OUT_SIDE) : col_acc);
    assign col_end_nxt = r_col_end + SIDE_W'(r_q) + SIDE_W'(col_carry);
    assign row_acc     = {1'b0, r_row_rem} + {1'b0, r_r};
    assign row_carry   = row_acc >= (REM_W + 1)'(OUT_SIDE);
    assign row_rem_nxt = REM_W'(row_carry ? row_acc - (REM_W + 1)'(OUT_SIDE) : row_acc);
    assign row_end_nxt = r_row_end + SIDE_W'(r_q) + SIDE_W'(row_carry);

    always_comb begin
        n_src_col   = r_src_col;
        n_src_row   = r_src_row;
        n_grid_col  = r_grid_col;
        n_grid_row  = r_grid_row;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_start = r_row_start;
        n_row_end   = r_row_end;
        n_col_rem   = r_col_rem;
        n_row_rem   = r_row_rem;
        if (i_cmd.init) begin
            n_src_col   = '0;
            n_src_row   = '0;
            n_grid_col  = '0;
            n_grid_row  = '0;
            n_col_start = r_x_lo;
            n_col_end   = r_x_lo + SIDE_W'(q_fix);
            n_row_start = r_y_lo;
            n_row_end   = r_y_lo + SIDE_W'(q_fix);
            n_col_rem   = r_fix;
            n_row_rem   = r_fix;
        end else if (i_cmd.step) begin
            if (x_nxt < r_width) begin
                n_src_col = POS_W'(x_nxt);
                if (col_hit && !last_col) begin
                    n_grid_col  = r_grid_col + 1'b1;
                    n_col_start = r_col_end;
                    n_col_end   = col_end_nxt;
                    n_col_rem   = col_rem_nxt;
                end
            end else begin
                n_src_col   = '0;
                n_grid_col  = '0;
                n_col_start = r_x_lo;
                n_col_end   = r_x_lo + SIDE_W'(r_q);
                n_col_rem   = r_r;
                if (y_nxt < r_height) begin
                    n_src_row = POS_W'(y_nxt);
                    if (row_hit && !last_row) begin
                        n_grid_row  = r_grid_row + 1'b1;
                        n_row_start = r_row_end;
                        n_row_end   = row_end_nxt;
                        n_row_rem   = row_rem_nxt;
                    end
                end else begin
                    n_src_row   = '0;
                    n_grid_row  = '0;
                    n_row_start = r_y_lo;
                    n_row_end   = r_y_lo + SIDE_W'(r_q);
                    n_row_rem   = r_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_grid_col <= '0;
            r_grid_row <= '0;
        end else begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_grid_col <= n_grid_col;
            r_grid_row <= n_grid_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_start <= n_col_start;
        r_col_end   <= n_col_end;
        r_row_start <= n_row_start;
        r_row_end   <= n_row_end;
        r_col_rem   <= n_col_rem;
        r_row_rem   <= n_row_rem;
    end

    // Column sums: registered read at the next grid column, with write forwarding.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_new[c] = r_rd[c] + SUM_W'(i_pixel[c*CH_W +: CH_W]);
        end
    end

    assign mem_we    = i_cmd.step && in_crop;
    assign mem_wdata = emit ? '0 : sum_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_grid_col] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[r_grid_col] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_rd <= '0;
        end else if (mem_we && r_grid_col == n_grid_col) begin
            r_rd <= mem_wdata;
        end else if (r_valid[n_grid_col]) begin
            r_rd <= r_mem[n_grid_col];
        end else begin
            r_rd <= '0;
        end
    end

    // Restoring division, one quotient bit per cycle for all three channels.
    assign trial = DIV_W'(r_cnt) << i_cmd.div_bit;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            qbit[c]     = DIV_W'(r_drem[c]) >= trial;
            drem_nxt[c] = qbit[c] ? SUM_W'(DIV_W'(r_drem[c]) - trial) : r_drem[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_drem     <= sum_new;
            r_bw       <= BLK_W'(r_col_end - r_col_start);
            r_bh       <= BLK_W'(r_row_end - r_row_start);
            r_tag_col  <= r_grid_col;
            r_tag_row  <= r_grid_row;
            r_tag_last <= last_col && last_row;
        end
        if (i_cmd.mul) begin
            r_cnt <= CNT_W'(r_bw) * CNT_W'(r_bh);
        end
        if (i_cmd.div_step) begin
            r_drem <= drem_nxt;
            for (int c = 0; c < 3; c++) begin
                r_quo[c] <= {r_quo[c][CH_W-2:0], qbit[c]};
            end
        end
        if (i_cmd.load_out) begin
            r_out_quo  <= r_quo;
            r_out_col  <= r_tag_col;
            r_out_row  <= r_tag_row;
            r_out_last <= r_tag_last;
        end
    end

    assign o_tdata = {{OUT_PAD_W{1'b0}}, r_out_row, r_out_col, r_out_quo};
    assign o_tlast = r_out_last;

endmodule

@@ hw/rtl/center_crop_area_downscale.sv @@
// Top level of the center crop area downscaler: controller plus datapath.
// Depends on ccad_pkg, ccad_ctrl and ccad_dpath.
//
// Channel   Dir  Contents (lowest bit first)
// s_axis    in   tdata: in_red, in_green, in_blue
// m_axis    out  tdata: out_red, out_green, out_blue, out_col, out_row; tlast: frame_done
// i_cfg_*   in   index 0 source_width, index 1 source_height
//
// A source pixel that completes no block leaves the controller ready for the next pixel.
// A pixel that completes a block passes through accept, count multiply and
// eight steps of the bit-serial divider, then a load of the output register.
// After reset and after each configuration write, s_axis_tready is low during
// crop geometry setup in the GEOM and INIT states. A finished result waits in the output
// register while further pixels are taken; the divider holds if it is still full.
`timescale 1ns / 1ps

module center_crop_area_downscale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ccad_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ccad_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // in_red, in_green, in_blue
    input  logic [ccad_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_red, out_green, out_blue, out_col, out_row, zero fill
    output logic [ccad_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import ccad_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ccad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ccad_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_pixel    (s_axis_tdata),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast)
    );

endmodule
